// ===== hdl/lsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrm_pkg: shared types and constants of the lidar scan ROI mask
// Item layouts, register map, fixed-point constants and the CORDIC
// arctangent table used by the front end, the CORDIC cells and the back end.
// ----------------------------------------------------------------------------
package lsrm_pkg;

  localparam int AngW        = 24;
  localparam int AngStepW    = 21;
  localparam int CoordW      = 18;
  localparam int RangeW      = 16;
  localparam int VecW        = 32;
  localparam int ZW          = 24;
  localparam int CordicIters = 16;
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = 24;

  localparam logic signed [AngW-1:0] AngPi     = 24'sd3294199;
  localparam logic signed [AngW-1:0] AngHalfPi = 24'sd1647099;
  localparam logic signed [AngW-1:0] AngTwoPi  = 24'sd6588397;
  localparam logic signed [AngW-1:0] AngMax    = 24'sd8388607;
  localparam logic signed [AngW-1:0] AngMin    = -24'sd8388608;

  localparam logic signed [VecW-1:0] CordicX0 = 32'sd652032874;

  localparam logic signed [CoordW-1:0] CoordMax = 18'sd131071;
  localparam logic signed [CoordW-1:0] CoordMin = -18'sd131072;

  localparam logic signed [ZW-1:0] AtanTab [0:CordicIters-1] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
    24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
    24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32
  };

  typedef enum logic [CfgIndexW-1:0] {
    RegScanAngleStart = 3'd0,
    RegAngleStep      = 3'd1,
    RegWindowLow      = 3'd2,
    RegWindowHigh     = 3'd3,
    RegBoxXLow        = 3'd4,
    RegBoxXHigh       = 3'd5,
    RegBoxYLow        = 3'd6,
    RegBoxYHigh       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RangeW-1:0] range_in;
    logic              scan_last;
  } in_item_t;

  typedef struct packed {
    logic [RangeW-1:0] range_out;
    logic              masked;
    logic              scan_end;
  } out_item_t;

  typedef struct packed {
    logic signed [AngW-1:0]   scan_angle_start;
    logic [AngStepW-1:0]      angle_step;
    logic signed [AngW-1:0]   window_low;
    logic signed [AngW-1:0]   window_high;
    logic signed [CoordW-1:0] box_x_low;
    logic signed [CoordW-1:0] box_x_high;
    logic signed [CoordW-1:0] box_y_low;
    logic signed [CoordW-1:0] box_y_high;
  } cfg_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    logic                   neg;
    logic                   in_win;
    logic [RangeW-1:0]      range;
    logic                   last;
  } cordic_bus_t;

  localparam cfg_t CfgReset = '{
    scan_angle_start: -24'sd3294199,
    angle_step:       21'd18301,
    window_low:       -24'sd1647099,
    window_high:      24'sd1647099,
    box_x_low:        -18'sd1280,
    box_x_high:       18'sd1280,
    box_y_low:        -18'sd256,
    box_y_high:       18'sd256
  };

endpackage

// ===== hdl/lsrm_front.sv =====
// ----------------------------------------------------------------------------
// lsrm_front: beam angle tracking and quadrant fold
// Keeps the running beam angle of the scan, then folds the angle into the
// CORDIC range and checks it against the angle window.
// ----------------------------------------------------------------------------
module lsrm_front
  import lsrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        dn_valid,
  input  logic        dn_ready,
  output cordic_bus_t dn_bus
);

  localparam logic signed [AngW+1:0] SumMax    = (AngW+2)'(AngMax);
  localparam logic signed [AngW+1:0] SumMin    = (AngW+2)'(AngMin);
  localparam logic signed [AngW:0]   Pi25      = (AngW+1)'(AngPi);
  localparam logic signed [AngW:0]   NegPi25   = -((AngW+1)'(AngPi));
  localparam logic signed [AngW:0]   TwoPi25   = (AngW+1)'(AngTwoPi);
  localparam logic signed [AngW:0]   Half25    = (AngW+1)'(AngHalfPi);
  localparam logic signed [AngW:0]   NegHalf25 = -((AngW+1)'(AngHalfPi));

  logic signed [AngW-1:0] beam_angle;
  logic signed [AngW-1:0] beam_angle_next;
  logic                   at_scan_start;
  logic                   a_valid;
  logic signed [AngW-1:0] a_ang;
  logic [RangeW-1:0]      a_range;
  logic                   a_last;
  logic                   b_valid;
  cordic_bus_t            b_bus;
  cordic_bus_t            b_bus_next;
  logic                   a_load;
  logic                   b_load;
  logic                   accept;
  logic signed [AngW+1:0] ang_sum;
  logic signed [AngW:0]   wide;
  logic signed [AngW:0]   wrapped;
  logic signed [AngW:0]   folded;
  logic                   neg;
  logic signed [ZW-1:0]   b_z;

  assign b_load   = !b_valid || dn_ready;
  assign a_load   = !a_valid || b_load;
  assign in_ready = a_load;
  assign accept   = in_valid && a_load;

  always_comb begin
    ang_sum = {{2{beam_angle[AngW-1]}}, beam_angle}
            + {2'b00, {(AngW - AngStepW){1'b0}}, cfg.angle_step};
    if (at_scan_start) begin
      beam_angle_next = cfg.scan_angle_start;
    end else if (ang_sum > SumMax) begin
      beam_angle_next = AngMax;
    end else if (ang_sum < SumMin) begin
      beam_angle_next = AngMin;
    end else begin
      beam_angle_next = ang_sum[AngW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle    <= '0;
      at_scan_start <= 1'b1;
      a_valid       <= 1'b0;
    end else if (a_load) begin
      a_valid <= in_valid;
      if (in_valid) begin
        beam_angle    <= beam_angle_next;
        at_scan_start <= in_item.scan_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ang   <= beam_angle_next;
      a_range <= in_item.range_in;
      a_last  <= in_item.scan_last;
    end
  end

  always_comb begin
    wide = {a_ang[AngW-1], a_ang};
    if (wide > Pi25) begin
      wrapped = wide - TwoPi25;
    end else if (wide < NegPi25) begin
      wrapped = wide + TwoPi25;
    end else begin
      wrapped = wide;
    end
    if (wrapped > Half25) begin
      folded = wrapped - Pi25;
      neg    = 1'b1;
    end else if (wrapped < NegHalf25) begin
      folded = wrapped + Pi25;
      neg    = 1'b1;
    end else begin
      folded = wrapped;
      neg    = 1'b0;
    end
    b_bus_next.x      = CordicX0;
    b_bus_next.y      = '0;
    b_bus_next.z      = folded[ZW-1:0];
    b_bus_next.neg    = neg;
    b_bus_next.in_win = (a_ang >= cfg.window_low) && (a_ang <= cfg.window_high);
    b_bus_next.range  = a_range;
    b_bus_next.last   = a_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      b_bus <= b_bus_next;
    end
  end

  assign dn_valid = b_valid;
  assign dn_bus   = b_bus;
  assign b_z      = b_bus.z;

  assert property (@(posedge clk) disable iff (rst)
    accept && at_scan_start |=> a_ang == $past(cfg.scan_angle_start))
    else $error("First item of a scan did not take the start angle.");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> a_valid && a_ang == beam_angle)
    else $error("Stage angle and running beam angle disagree.");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> at_scan_start == $past(in_item.scan_last))
    else $error("Scan start flag did not follow the last item marker.");

  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_z <= AngHalfPi) && (b_z >= -AngHalfPi))
    else $error("Folded angle lies outside the CORDIC range.");

endmodule

// ===== hdl/lsrm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lsrm_cordic_cell: one CORDIC rotation step
// Rotates the vector by the fixed arctangent of its step and hands the
// result, with the item's side fields, to the next cell.
// ----------------------------------------------------------------------------
module lsrm_cordic_cell
  import lsrm_pkg::*;
#(
  parameter int Iter = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  cordic_bus_t up_bus,
  output logic        dn_valid,
  input  logic        dn_ready,
  output cordic_bus_t dn_bus
);

  logic                   valid;
  cordic_bus_t            bus;
  cordic_bus_t            bus_next;
  logic signed [VecW-1:0] x_in;
  logic signed [VecW-1:0] y_in;
  logic signed [VecW-1:0] dx;
  logic signed [VecW-1:0] dy;
  logic signed [ZW-1:0]   z_in;
  logic                   load;

  assign load     = !valid || dn_ready;
  assign up_ready = load;

  always_comb begin
    x_in     = up_bus.x;
    y_in     = up_bus.y;
    z_in     = up_bus.z;
    dx       = y_in >>> Iter;
    dy       = x_in >>> Iter;
    bus_next = up_bus;
    if (!z_in[ZW-1]) begin
      bus_next.x = x_in - dx;
      bus_next.y = y_in + dy;
      bus_next.z = z_in - AtanTab[Iter];
    end else begin
      bus_next.x = x_in + dx;
      bus_next.y = y_in - dy;
      bus_next.z = z_in + AtanTab[Iter];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      bus <= bus_next;
    end
  end

  assign dn_valid = valid;
  assign dn_bus   = bus;

endmodule

// ===== hdl/lsrm_back.sv =====
// ----------------------------------------------------------------------------
// lsrm_back: projection and rectangle test
// Restores the quadrant sign, scales cos and sin by the range, rounds and
// saturates to Q9.8 and decides the mask flag of the item.
// ----------------------------------------------------------------------------
module lsrm_back
  import lsrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        up_valid,
  output logic        up_ready,
  input  cordic_bus_t up_bus,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  localparam int ProdW  = RangeW + 1 + VecW;
  localparam int FracSh = 30;
  localparam int QW     = ProdW - FracSh;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) <<< (FracSh - 1);
  localparam logic signed [QW-1:0]    QMax      = QW'(CoordMax);
  localparam logic signed [QW-1:0]    QMin      = QW'(CoordMin);

  logic                     s_valid;
  logic signed [VecW-1:0]   s_c;
  logic signed [VecW-1:0]   s_s;
  logic [RangeW-1:0]        s_range;
  logic                     s_last;
  logic                     s_win;
  logic                     m_valid;
  logic signed [ProdW-1:0]  m_px;
  logic signed [ProdW-1:0]  m_py;
  logic [RangeW-1:0]        m_range;
  logic                     m_last;
  logic                     m_win;
  logic                     r_valid;
  logic signed [CoordW-1:0] r_x;
  logic signed [CoordW-1:0] r_y;
  logic [RangeW-1:0]        r_range;
  logic                     r_last;
  logic                     r_win;
  logic                     o_valid;
  out_item_t                o_item;
  logic                     s_load;
  logic                     m_load;
  logic                     r_load;
  logic                     o_load;
  logic signed [VecW-1:0]   up_x;
  logic signed [VecW-1:0]   up_y;
  logic signed [ProdW-1:0]  rng_ext;
  logic signed [ProdW-1:0]  c_ext;
  logic signed [ProdW-1:0]  s_ext;
  logic signed [ProdW-1:0]  tx;
  logic signed [ProdW-1:0]  ty;
  logic signed [QW-1:0]     qx;
  logic signed [QW-1:0]     qy;
  logic signed [CoordW-1:0] x_next;
  logic signed [CoordW-1:0] y_next;
  logic                     in_box;

  assign o_load   = !o_valid || out_ready;
  assign r_load   = !r_valid || o_load;
  assign m_load   = !m_valid || r_load;
  assign s_load   = !s_valid || m_load;
  assign up_ready = s_load;

  assign up_x = up_bus.x;
  assign up_y = up_bus.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      m_valid <= 1'b0;
      r_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s_load) begin
        s_valid <= up_valid;
      end
      if (m_load) begin
        m_valid <= s_valid;
      end
      if (r_load) begin
        r_valid <= m_valid;
      end
      if (o_load) begin
        o_valid <= r_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_load && up_valid) begin
      s_c     <= up_bus.neg ? -up_x : up_x;
      s_s     <= up_bus.neg ? -up_y : up_y;
      s_range <= up_bus.range;
      s_last  <= up_bus.last;
      s_win   <= up_bus.in_win;
    end
  end

  always_comb begin
    rng_ext = ProdW'($signed({1'b0, s_range}));
    c_ext   = ProdW'(s_c);
    s_ext   = ProdW'(s_s);
  end

  always_ff @(posedge clk) begin
    if (m_load && s_valid) begin
      m_px    <= rng_ext * c_ext;
      m_py    <= rng_ext * s_ext;
      m_range <= s_range;
      m_last  <= s_last;
      m_win   <= s_win;
    end
  end

  always_comb begin
    tx = m_px + RoundHalf;
    ty = m_py + RoundHalf;
    qx = tx[ProdW-1:FracSh];
    qy = ty[ProdW-1:FracSh];
    if (qx > QMax) begin
      x_next = CoordMax;
    end else if (qx < QMin) begin
      x_next = CoordMin;
    end else begin
      x_next = qx[CoordW-1:0];
    end
    if (qy > QMax) begin
      y_next = CoordMax;
    end else if (qy < QMin) begin
      y_next = CoordMin;
    end else begin
      y_next = qy[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r_load && m_valid) begin
      r_x     <= x_next;
      r_y     <= y_next;
      r_range <= m_range;
      r_last  <= m_last;
      r_win   <= m_win;
    end
  end

  assign in_box = (r_x >= cfg.box_x_low) && (r_x <= cfg.box_x_high)
               && (r_y >= cfg.box_y_low) && (r_y <= cfg.box_y_high);

  always_ff @(posedge clk) begin
    if (o_load && r_valid) begin
      o_item.range_out <= r_range;
      o_item.masked    <= !in_box || r_win;
      o_item.scan_end  <= r_last;
    end
  end

  assign out_valid = o_valid;
  assign out_item  = o_item;

endmodule

// ===== hdl/lidar_scan_roi_mask.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_roi_mask: rectangular region-of-interest mask for lidar scans
// Range samples of a scan enter in beam order on the in channel. Each sample
// gets a running beam angle, is rotated into x and y by a chain of sixteen
// CORDIC cells and leaves on the out channel with its range unchanged and a
// mask flag set when it falls outside the rectangle or inside the angle
// window. The sample that carries scan_last ends the scan, and the next
// sample restarts at the configured start angle.
// Registers are written on the cfg channel, which is always ready; write
// them only while no item is in flight.
// Every item passes from acceptance to its result through two front stages,
// sixteen CORDIC cells and four stages for sign, multiply, rounding and the
// rectangle test. One item is accepted per cycle while the chain is not full.
// When the receiver stalls, the chain fills up behind the output register
// and in_ready falls only once every stage holds an item.
// Reset clears all stage valids, restores the register defaults and starts
// a new scan.
// ----------------------------------------------------------------------------
module lidar_scan_roi_mask
  import lsrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t        cfg;
  logic        chain_valid [0:CordicIters];
  logic        chain_ready [0:CordicIters];
  cordic_bus_t chain_bus   [0:CordicIters];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        RegScanAngleStart: cfg.scan_angle_start <= $signed(cfg_data[AngW-1:0]);
        RegAngleStep:      cfg.angle_step       <= cfg_data[AngStepW-1:0];
        RegWindowLow:      cfg.window_low       <= $signed(cfg_data[AngW-1:0]);
        RegWindowHigh:     cfg.window_high      <= $signed(cfg_data[AngW-1:0]);
        RegBoxXLow:        cfg.box_x_low        <= $signed(cfg_data[CoordW-1:0]);
        RegBoxXHigh:       cfg.box_x_high       <= $signed(cfg_data[CoordW-1:0]);
        RegBoxYLow:        cfg.box_y_low        <= $signed(cfg_data[CoordW-1:0]);
        RegBoxYHigh:       cfg.box_y_high       <= $signed(cfg_data[CoordW-1:0]);
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  lsrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_bus   (chain_bus[0])
  );

  for (genvar i = 0; i < CordicIters; i++) begin : g_cell
    lsrm_cordic_cell #(
      .Iter (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_bus   (chain_bus[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_bus   (chain_bus[i+1])
    );
  end

  lsrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (chain_valid[CordicIters]),
    .up_ready  (chain_ready[CordicIters]),
    .up_bus    (chain_bus[CordicIters]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/lidar_scan_roi_mask_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_roi_mask_tb: self-checking testbench of the lidar scan ROI mask
// Range samples are sent in scans under a series of register settings. Each
// accepted item is run through a bit-exact model of the beam angle, the
// CORDIC rotation and the rectangle and window tests. Every result is
// compared with the oldest prediction. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module lidar_scan_roi_mask_tb;
  import lsrm_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 30;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 195;

  typedef enum int {RxOpen, RxCoin, RxMostly, RxChoke} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  lidar_scan_roi_mask dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cfg_t        roi_cfg = CfgReset;
  longint      beam_angle_m = 0;
  bit          scan_start_m = 1'b1;

  in_item_t    pending_samples[$];
  out_item_t   expected_samples[$];

  int pushed_count   = 0;
  int accepted_count = 0;
  int scans_seen     = 0;
  int results_checked = 0;
  int masked_count   = 0;
  int errors         = 0;
  int settings_run   = 0;
  int cycle_count    = 0;

  int       burst_left = 1;
  int       gap_left   = 0;
  rx_mode_t rx_mode    = RxOpen;
  int       rx_left    = 0;

  function automatic out_item_t mask_sample(in_item_t it);
    longint    ang, a, cx, cy, z, dx, dy, px, py, rng, step;
    bit        flip, in_box, in_win;
    out_item_t r;
    step = longint'(roi_cfg.angle_step);
    if (scan_start_m) begin
      ang = longint'(roi_cfg.scan_angle_start);
    end else begin
      ang = beam_angle_m + step;
      if (ang > AngMax) ang = longint'(AngMax);
      if (ang < AngMin) ang = longint'(AngMin);
    end
    beam_angle_m = ang;
    scan_start_m = it.scan_last;

    a = ang;
    while (a > AngPi) a = a - AngTwoPi;
    while (a < -AngPi) a = a + AngTwoPi;
    flip = 1'b0;
    if (a > AngHalfPi) begin
      a = a - AngPi;
      flip = 1'b1;
    end else if (a < -AngHalfPi) begin
      a = a + AngPi;
      flip = 1'b1;
    end
    cx = longint'(CordicX0);
    cy = 0;
    z  = a;
    for (int i = 0; i < CordicIters; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - AtanTab[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + AtanTab[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end

    rng = longint'(it.range_in);
    px = (rng * cx + (longint'(1) << 29)) >>> 30;
    py = (rng * cy + (longint'(1) << 29)) >>> 30;
    if (px > CoordMax) px = longint'(CoordMax);
    if (px < CoordMin) px = longint'(CoordMin);
    if (py > CoordMax) py = longint'(CoordMax);
    if (py < CoordMin) py = longint'(CoordMin);

    in_box = px >= roi_cfg.box_x_low && px <= roi_cfg.box_x_high &&
             py >= roi_cfg.box_y_low && py <= roi_cfg.box_y_high;
    in_win = ang >= roi_cfg.window_low && ang <= roi_cfg.window_high;

    r.range_out = it.range_in;
    r.masked    = !in_box || in_win;
    r.scan_end  = it.scan_last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(mask_sample(in_item));
        accepted_count++;
        if (in_item.scan_last) scans_seen++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_item  <= pending_samples.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(10, 25);
            else gap_left = $urandom_range(1, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 150);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RxOpen:   out_ready <= 1'b1;
        RxCoin:   out_ready <= 1'($urandom_range(0, 1));
        RxMostly: out_ready <= ($urandom_range(0, 7) != 0);
        default:  out_ready <= (rx_left % 16 < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected item: range_out %0d masked %0b scan_end %0b",
                   out_item.range_out, out_item.masked, out_item.scan_end);
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (out_item.masked === 1'b1) masked_count++;
        if (out_item.range_out !== want.range_out || out_item.masked !== want.masked ||
            out_item.scan_end !== want.scan_end) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch on item %0d: range_out %0d/%0d masked %0b/%0b scan_end %0b/%0b",
                     results_checked, want.range_out, out_item.range_out, want.masked,
                     out_item.masked, want.scan_end, out_item.scan_end);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d items outstanding.", cycle_count,
             expected_samples.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] word;
    word = val;
    if (idx == RegAngleStep) word[23:21] = 3'($urandom);
    else if (idx >= RegBoxXLow) word[23:18] = 6'($urandom);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegScanAngleStart: roi_cfg.scan_angle_start = word;
      RegAngleStep:      roi_cfg.angle_step       = word[20:0];
      RegWindowLow:      roi_cfg.window_low       = word;
      RegWindowHigh:     roi_cfg.window_high      = word;
      RegBoxXLow:        roi_cfg.box_x_low        = word[17:0];
      RegBoxXHigh:       roi_cfg.box_x_high       = word[17:0];
      RegBoxYLow:        roi_cfg.box_y_low        = word[17:0];
      default:           roi_cfg.box_y_high       = word[17:0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cfg(cfg_t c, bit all);
    if (all || $urandom_range(0, 4) != 0)
      write_reg(RegScanAngleStart, c.scan_angle_start);
    if (all || $urandom_range(0, 4) != 0)
      write_reg(RegAngleStep, CfgDataW'(c.angle_step));
    if (all || $urandom_range(0, 4) != 0) write_reg(RegWindowLow, c.window_low);
    if (all || $urandom_range(0, 4) != 0) write_reg(RegWindowHigh, c.window_high);
    if (all || $urandom_range(0, 4) != 0) write_reg(RegBoxXLow, CfgDataW'(c.box_x_low));
    if (all || $urandom_range(0, 4) != 0) write_reg(RegBoxXHigh, CfgDataW'(c.box_x_high));
    if (all || $urandom_range(0, 4) != 0) write_reg(RegBoxYLow, CfgDataW'(c.box_y_low));
    if (all || $urandom_range(0, 4) != 0) write_reg(RegBoxYHigh, CfgDataW'(c.box_y_high));
    settings_run++;
  endtask

  function automatic void pick_bounds(output logic signed [CoordW-1:0] lo,
                                      output logic signed [CoordW-1:0] hi);
    int base;
    case ($urandom_range(0, 6))
      0: begin
        base = $urandom_range(0, 2000);
        lo = CoordW'(base);
        hi = CoordW'(base - int'($urandom_range(1, 2000)));
      end
      1: begin
        lo = CoordMin;
        hi = CoordMax;
      end
      2: begin
        lo = CoordW'($urandom);
        hi = CoordW'($urandom);
      end
      default: begin
        lo = CoordW'(-int'($urandom_range(0, 6000)));
        hi = CoordW'($urandom_range(0, 6000));
      end
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   base;
    case ($urandom_range(0, 5))
      0:       c.scan_angle_start = AngW'($urandom);
      1:       c.scan_angle_start = $urandom_range(0, 1) ? AngMax : AngMin;
      default: c.scan_angle_start = AngW'(int'($urandom_range(0, 6588397)) - 3294199);
    endcase
    case ($urandom_range(0, 4))
      0: c.angle_step = AngStepW'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0:       c.angle_step = '0;
          1:       c.angle_step = 21'd1048576;
          default: c.angle_step = '1;
        endcase
      end
      default: c.angle_step = AngStepW'($urandom_range(0, 40000));
    endcase
    case ($urandom_range(0, 4))
      0: begin
        base = $urandom_range(0, 1000000);
        c.window_low  = AngW'(base);
        c.window_high = AngW'(base - int'($urandom_range(1, 1000000)));
      end
      1: begin
        c.window_low  = AngW'($urandom);
        c.window_high = AngW'($urandom);
      end
      2: begin
        c.window_low  = AngMin;
        c.window_high = AngMax;
      end
      default: begin
        base = int'($urandom_range(0, 6588397)) - 3294199;
        c.window_low  = AngW'(base);
        c.window_high = AngW'(base + int'($urandom_range(0, 2000000)));
      end
    endcase
    pick_bounds(c.box_x_low, c.box_x_high);
    pick_bounds(c.box_y_low, c.box_y_high);
    return c;
  endfunction

  function automatic logic [RangeW-1:0] pick_range();
    case ($urandom_range(0, 6))
      0: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'd1;
          default: return 16'h8000;
        endcase
      end
      1, 2:    return RangeW'($urandom);
      3:       return RangeW'($urandom_range(0, 16384));
      default: return RangeW'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic queue_item(logic [RangeW-1:0] r, logic last);
    pending_samples.push_back('{range_in: r, scan_last: last});
    pushed_count++;
  endtask

  task automatic queue_random_scans(int n);
    int first, len;
    first = pushed_count;
    while (pushed_count - first < n) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(150, 380);
        2, 3:    len = $urandom_range(41, 120);
        default: len = $urandom_range(1, 40);
      endcase
      if (len == 0) queue_item(pick_range(), 1'($urandom_range(0, 1)));
      for (int k = 0; k < len; k++) queue_item(pick_range(), k == len - 1);
    end
  endtask

  task automatic wait_pipeline_empty();
    do @(posedge clk);
    while (accepted_count != pushed_count || expected_samples.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settings_run = 1;

    queue_item(16'd0, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd1, 1'b0);
    queue_item(16'd256, 1'b0);
    queue_item(16'd1280, 1'b1);
    queue_item(16'h8000, 1'b1);
    queue_item(16'hFFFF, 1'b1);
    queue_item(16'd42, 1'b1);
    wait_pipeline_empty();

    // Saturating angle, oversized step, empty window, widest rectangle.
    c = '{scan_angle_start: AngMax, angle_step: '1, window_low: 24'sd100,
          window_high: -24'sd100, box_x_low: CoordMin, box_x_high: CoordMax,
          box_y_low: CoordMin, box_y_high: CoordMax};
    load_cfg(c, 1'b1);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd300, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd128, 1'b1);
    wait_pipeline_empty();

    // Most negative angle, zero step and an empty rectangle.
    c.scan_angle_start = AngMin;
    c.angle_step       = '0;
    c.box_x_low        = 18'sd10;
    c.box_x_high       = -18'sd10;
    load_cfg(c, 1'b1);
    queue_item(16'd0, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd300, 1'b1);
    wait_pipeline_empty();

    // Quarter-turn steps that land exactly on the window bounds.
    c = '{scan_angle_start: -AngPi, angle_step: AngStepW'(AngHalfPi),
          window_low: -AngHalfPi, window_high: AngHalfPi, box_x_low: CoordMin,
          box_x_high: CoordMax, box_y_low: CoordMin, box_y_high: CoordMax};
    load_cfg(c, 1'b1);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd1000, 1'b0);
    queue_item(16'd0, 1'b0);
    queue_item(16'd2560, 1'b0);
    queue_item(16'hFFFF, 1'b1);
    wait_pipeline_empty();

    for (int p = 0; p < RandomPhases; p++) begin
      load_cfg(random_cfg(), 1'b0);
      queue_random_scans(PhaseItems);
      wait_pipeline_empty();
    end

    $display("Checked %0d results from %0d scans under %0d register settings.",
             results_checked, scans_seen, settings_run);
    $display("%0d results were masked, %0d mismatches found.", masked_count, errors);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
